/* rtl/core/riexec_pkg.sv */
// Package for the RV32I I-type execute block.
// Holds the request/response transaction types and the mode and funct3 codes.
// No dependencies.
package riexec_pkg;

   localparam int unsigned XLEN = 32;

   // Instruction group
   localparam logic [1:0] MODE_ALU   = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_JALR  = 2'd2;
   localparam logic [1:0] MODE_FENCE = 2'd3;

   // Immediate ALU funct3
   localparam logic [2:0] F3_ADDI  = 3'd0;
   localparam logic [2:0] F3_SLLI  = 3'd1;
   localparam logic [2:0] F3_SLTI  = 3'd2;
   localparam logic [2:0] F3_SLTIU = 3'd3;
   localparam logic [2:0] F3_XORI  = 3'd4;
   localparam logic [2:0] F3_SRXI  = 3'd5;
   localparam logic [2:0] F3_ORI   = 3'd6;
   localparam logic [2:0] F3_ANDI  = 3'd7;

   // Load funct3
   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;

   // Fence funct3
   localparam logic [2:0] F3_FENCE  = 3'd0;
   localparam logic [2:0] F3_FENCEI = 3'd1;

   localparam logic [XLEN-1:0] PC_STEP = 32'd4;

   typedef struct packed {
      logic [1:0]      mode;
      logic [XLEN-1:0] instruction;
      logic [XLEN-1:0] source_value;
      logic [XLEN-1:0] current_pc;
      logic [XLEN-1:0] load_word;
   } riexec_req_type;

   typedef struct packed {
      logic            ok;
      logic            reg_write;
      logic [4:0]      dest_reg;
      logic [XLEN-1:0] write_value;
      logic [XLEN-1:0] next_pc;
      logic            mem_read;
      logic [XLEN-1:0] mem_address;
   } riexec_rsp_type;

endpackage

/* rtl/core/rv32i_immediate_execute.sv */
// RV32I I-type execute stage: immediate ALU, loads, JALR and fences.
// Depends on riexec_pkg for the transaction types and decode codes.
// Timing: a transaction is registered on accept and decoded and executed in
// the next cycle. Its result is registered once more and then driven on
// rsp_data with rsp_valid from the response register. One instruction is
// taken every cycle. busy stays low because the block keeps no state across
// instructions and the result register is rewritten each cycle. The result
// is shown for one cycle only, so the receiver must capture it then. An
// unrecognized funct3 (or SLLI with bit 30 set) returns ok low with every
// other field zero.
module rv32i_immediate_execute (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  riexec_pkg::riexec_req_type req_data,
   output logic                    rsp_valid,
   output riexec_pkg::riexec_rsp_type rsp_data
);
   import riexec_pkg::*;

   logic           req_valid_ff, req_valid_in;
   riexec_req_type req_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   riexec_rsp_type rsp_ff, rsp_in;

   logic [2:0]      f3;
   logic            b30;
   logic [XLEN-1:0] imm;
   logic [4:0]      shamt;
   logic [XLEN-1:0] eff_addr;
   logic [XLEN-1:0] pc_plus4;
   logic            ok;
   logic            wr;
   logic            rd_en;
   logic [XLEN-1:0] val;
   logic [XLEN-1:0] npc;

   assign busy         = 1'b0;
   assign req_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // decode
   assign f3       = req_ff.instruction[14:12];
   assign b30      = req_ff.instruction[30];
   assign imm      = {{(XLEN-12){req_ff.instruction[31]}}, req_ff.instruction[31:20]};
   assign shamt    = imm[4:0];
   assign eff_addr = req_ff.source_value + imm;
   assign pc_plus4 = req_ff.current_pc + PC_STEP;

   always_comb begin
      ok    = 1'b1;
      wr    = 1'b0;
      rd_en = 1'b0;
      val   = '0;
      npc   = pc_plus4;
      unique case (req_ff.mode)
         MODE_ALU: begin
            wr = 1'b1;
            unique case (f3)
               F3_ADDI:  val = eff_addr;
               F3_SLTI:  val = {{(XLEN-1){1'b0}},
                                ($signed(req_ff.source_value) < $signed(imm))};
               F3_SLTIU: val = {{(XLEN-1){1'b0}}, (req_ff.source_value < imm)};
               F3_XORI:  val = req_ff.source_value ^ imm;
               F3_ORI:   val = req_ff.source_value | imm;
               F3_ANDI:  val = req_ff.source_value & imm;
               F3_SLLI: begin
                  if (!b30) begin
                     val = req_ff.source_value << shamt;
                  end else begin
                     ok = 1'b0;
                  end
               end
               F3_SRXI: begin
                  if (b30) begin
                     val = XLEN'($signed(req_ff.source_value) >>> shamt);
                  end else begin
                     val = req_ff.source_value >> shamt;
                  end
               end
               default: ok = 1'b0;
            endcase
         end
         MODE_LOAD: begin
            wr    = 1'b1;
            rd_en = 1'b1;
            unique case (f3)
               F3_LB:   val = {{(XLEN-8){req_ff.load_word[7]}}, req_ff.load_word[7:0]};
               F3_LH:   val = {{(XLEN-16){req_ff.load_word[15]}}, req_ff.load_word[15:0]};
               F3_LW:   val = req_ff.load_word;
               F3_LBU:  val = {{(XLEN-8){1'b0}}, req_ff.load_word[7:0]};
               F3_LHU:  val = {{(XLEN-16){1'b0}}, req_ff.load_word[15:0]};
               default: ok = 1'b0;
            endcase
         end
         MODE_JALR: begin
            wr  = 1'b1;
            val = pc_plus4;
            npc = {eff_addr[XLEN-1:1], 1'b0};
         end
         MODE_FENCE: begin
            if (f3 != F3_FENCE && f3 != F3_FENCEI) begin
               ok = 1'b0;
            end
         end
         default: ok = 1'b0;
      endcase
   end

   // an unrecognized instruction has no effects at all
   always_comb begin
      rsp_valid_in        = req_valid_ff;
      rsp_in.ok           = ok;
      rsp_in.reg_write    = ok & wr;
      rsp_in.dest_reg     = (ok && wr) ? req_ff.instruction[11:7] : 5'd0;
      rsp_in.write_value  = (ok && wr) ? val : '0;
      rsp_in.next_pc      = ok ? npc : '0;
      rsp_in.mem_read     = ok & rd_en;
      rsp_in.mem_address  = (ok && rd_en) ? eff_addr : '0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted transaction produced no result two cycles later");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |->
         (!rsp_data.reg_write && !rsp_data.mem_read && rsp_data.next_pc == '0
          && rsp_data.write_value == '0 && rsp_data.dest_reg == 5'd0))
      else $error("rejected instruction has side effects");

   a_load_writes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.mem_read) |-> (rsp_data.ok && rsp_data.reg_write))
      else $error("load without register write");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.mem_read) |-> (rsp_data.mem_address == '0))
      else $error("address driven without a memory read");
`endif

endmodule
